// ===== rtl/ctcg_pkg.sv =====
// shared types and constants of the ctc greedy decoder
`default_nettype none

package ctcg_pkg;

    localparam int SCORE_W   = 16;
    localparam int CFG_W     = 14;
    localparam int CLS_OUT_W = 13;
    localparam int SUM_W     = 27;
    localparam int CONF_W    = 16;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CONF_W-1:0] CONF_MAX = {CONF_W{1'b1}};

    localparam logic [CFG_W-1:0] NUM_CLASSES_RST = 14'd6625;
    localparam logic [CFG_W-1:0] VALID_KEYS_RST  = 14'd6625;

    typedef enum logic [0:0]
    {
        REG_NUM_CLASSES = 1'b0,
        REG_VALID_KEYS  = 1'b1
    } reg_index_t;

    typedef enum logic [0:0]
    {
        KIND_CHAR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic has_char;
        logic has_sum;
    } ev_flags_t;

endpackage

`default_nettype wire

// ===== rtl/ctcg_front.sv =====
// front end: config registers, per-step arg-max, emission decision and sequence totals
`default_nettype none

module ctcg_front
#(
    parameter int MAX_CLASSES = 8192,
    parameter int MAX_CHARS   = 1024,
    localparam int CLS_W = $clog2(MAX_CLASSES),
    localparam int CNT_W = $clog2(MAX_CHARS + 1)
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    input  wire                              cfg_index,
    input  wire [ctcg_pkg::CFG_W-1:0]        cfg_data,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire [ctcg_pkg::SCORE_W-1:0]      in_score,
    input  wire                              in_seq_end,
    input  wire                              q_full,
    output logic                             push,
    output ctcg_pkg::ev_flags_t              ev_flags,
    output logic [ctcg_pkg::CLS_OUT_W-1:0]   ev_class,
    output logic [ctcg_pkg::SCORE_W-1:0]     ev_score,
    output logic [CNT_W-1:0]                 ev_count,
    output logic [ctcg_pkg::SUM_W-1:0]       ev_sum
);

    localparam int CMP_W = 18;

    logic [ctcg_pkg::CFG_W-1:0]   num_classes_reg;
    logic [ctcg_pkg::CFG_W-1:0]   valid_keys_reg;
    logic [CLS_W-1:0]             cnt_reg;
    logic [CLS_W-1:0]             cnt_next;
    logic [ctcg_pkg::SCORE_W-1:0] best_score_reg;
    logic [CLS_W-1:0]             best_class_reg;
    logic [CLS_W-1:0]             prev_reg;
    logic [CLS_W-1:0]             prev_next;
    logic [ctcg_pkg::SUM_W-1:0]   sum_reg;
    logic [ctcg_pkg::SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    logic [ctcg_pkg::CFG_W-1:0]   n_eff;
    logic                         accept;
    logic                         take;
    logic [ctcg_pkg::SCORE_W-1:0] cur_score;
    logic [CLS_W-1:0]             cur_class;
    logic                         step_end;
    logic                         emit;
    logic                         counting;
    logic [ctcg_pkg::SUM_W:0]     sum_ext;
    logic [ctcg_pkg::SUM_W-1:0]   sum_upd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        n_eff = (num_classes_reg == '0) ? ctcg_pkg::CFG_W'(1) : num_classes_reg;
        if (CMP_W'(n_eff) > CMP_W'(MAX_CLASSES))
        begin
            n_eff = ctcg_pkg::CFG_W'(MAX_CLASSES);
        end
    end

    assign take      = (cnt_reg == '0) || (in_score > best_score_reg);
    assign cur_score = take ? in_score : best_score_reg;
    assign cur_class = take ? cnt_reg : best_class_reg;
    assign step_end  = in_seq_end || ((CMP_W'(cnt_reg) + CMP_W'(1)) >= CMP_W'(n_eff));
    assign emit      = step_end && (cur_class != '0) && (cur_class != prev_reg)
                       && (CMP_W'(cur_class) < CMP_W'(valid_keys_reg));
    assign counting  = emit && (CMP_W'(count_reg) < CMP_W'(MAX_CHARS));
    assign sum_ext   = {1'b0, sum_reg} + (ctcg_pkg::SUM_W + 1)'(cur_score);
    assign sum_upd   = sum_ext[ctcg_pkg::SUM_W] ? ctcg_pkg::SUM_MAX
                                                : sum_ext[ctcg_pkg::SUM_W-1:0];

    always_comb
    begin
        cnt_next   = step_end ? '0 : cnt_reg + CLS_W'(1);
        prev_next  = step_end ? cur_class : prev_reg;
        sum_next   = counting ? sum_upd : sum_reg;
        count_next = counting ? count_reg + CNT_W'(1) : count_reg;
    end

    assign push              = accept && (emit || in_seq_end);
    assign ev_flags.has_char = emit;
    assign ev_flags.has_sum  = in_seq_end;
    assign ev_class          = ctcg_pkg::CLS_OUT_W'(cur_class);
    assign ev_score          = cur_score;
    assign ev_count          = count_next;
    assign ev_sum            = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= ctcg_pkg::NUM_CLASSES_RST;
            valid_keys_reg  <= ctcg_pkg::VALID_KEYS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (ctcg_pkg::reg_index_t'(cfg_index))
                ctcg_pkg::REG_NUM_CLASSES: num_classes_reg <= cfg_data;
                ctcg_pkg::REG_VALID_KEYS:  valid_keys_reg  <= cfg_data;
                default:                   num_classes_reg <= num_classes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
            prev_reg       <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            best_score_reg <= cur_score;
            best_class_reg <= cur_class;
            cnt_reg        <= cnt_next;
            if (in_seq_end)
            begin
                prev_reg  <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                prev_reg  <= prev_next;
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ctcg_fifo.sv =====
// small register queue between front and back end, show-ahead read
`default_nettype none

module ctcg_fifo
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  wr_data,
    input  wire              pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LVL_W'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(DEPTH))
        else $error("queue level out of range");

endmodule

`default_nettype wire

// ===== rtl/ctcg_div.sv =====
// restoring divider for the mean score, one quotient bit per cycle
`default_nettype none

module ctcg_div
#(
    parameter int DIVISOR_W = 11
)
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  wire [ctcg_pkg::SUM_W-1:0]       dividend,
    input  wire [DIVISOR_W-1:0]             divisor,
    output logic                            done,
    output logic [ctcg_pkg::SUM_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(ctcg_pkg::SUM_W + 1);

    logic [ctcg_pkg::SUM_W-1:0] q_reg;
    logic [DIVISOR_W-1:0]       rem_reg;
    logic [DIVISOR_W-1:0]       div_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [DIVISOR_W:0]         trial;
    logic [DIVISOR_W:0]         diff;
    logic                       ge;

    assign trial    = {rem_reg, q_reg[ctcg_pkg::SUM_W-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign diff     = trial - {1'b0, div_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[ctcg_pkg::SUM_W-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                step_reg <= STEP_W'(ctcg_pkg::SUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ctcg_back.sv =====
// back end: expands queued events into character and summary results, output register
`default_nettype none

module ctcg_back
#(
    parameter int MAX_CHARS = 1024,
    localparam int CNT_W = $clog2(MAX_CHARS + 1)
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              q_empty,
    output logic                             pop,
    input  ctcg_pkg::ev_flags_t              ev_flags,
    input  wire [ctcg_pkg::CLS_OUT_W-1:0]    ev_class,
    input  wire [ctcg_pkg::SCORE_W-1:0]      ev_score,
    input  wire [CNT_W-1:0]                  ev_count,
    input  wire [ctcg_pkg::SUM_W-1:0]        ev_sum,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             out_kind,
    output logic [ctcg_pkg::CLS_OUT_W-1:0]   out_class,
    output logic [ctcg_pkg::SCORE_W-1:0]     out_score,
    output logic [ctcg_pkg::CONF_W-1:0]      out_conf,
    output logic [CNT_W-1:0]                 out_count,
    output logic                             out_last
);

    typedef enum logic [3:0]
    {
        ST_FETCH = 4'b0001,
        ST_CHAR  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_SUM   = 4'b1000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    ctcg_pkg::ev_flags_t            flags_reg;
    logic [ctcg_pkg::CLS_OUT_W-1:0] class_reg;
    logic [ctcg_pkg::SCORE_W-1:0]   score_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [ctcg_pkg::SUM_W-1:0]     sum_reg;

    logic                           out_valid_reg;
    logic                           kind_reg;
    logic [ctcg_pkg::CLS_OUT_W-1:0] oclass_reg;
    logic [ctcg_pkg::SCORE_W-1:0]   oscore_reg;
    logic [ctcg_pkg::CONF_W-1:0]    oconf_reg;
    logic [CNT_W-1:0]               ocount_reg;
    logic                           last_reg;

    logic                           out_free;
    logic                           load_char;
    logic                           load_sum;
    logic                           div_start;
    logic                           div_done;
    logic [ctcg_pkg::SUM_W-1:0]     div_dividend;
    logic [CNT_W-1:0]               div_divisor;
    logic [ctcg_pkg::SUM_W-1:0]     quotient;
    logic [ctcg_pkg::CONF_W-1:0]    conf;

    // a summary-only event starts the divider in the cycle it is popped
    assign div_dividend = (state_reg == ST_FETCH) ? ev_sum : sum_reg;
    assign div_divisor  = (state_reg == ST_FETCH) ? ev_count : count_reg;

    ctcg_div #(.DIVISOR_W(CNT_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (state_reg == ST_FETCH) && !q_empty;
    assign load_char = (state_reg == ST_CHAR) && out_free;
    assign load_sum  = (state_reg == ST_SUM) && out_free;

    always_comb
    begin
        conf = '0;
        if (count_reg != '0)
        begin
            conf = (quotient > ctcg_pkg::SUM_W'(ctcg_pkg::CONF_MAX))
                   ? ctcg_pkg::CONF_MAX : quotient[ctcg_pkg::CONF_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_FETCH:
            begin
                if (!q_empty)
                begin
                    if (ev_flags.has_char)
                    begin
                        state_next = ST_CHAR;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    state_next = flags_reg.has_sum ? ST_DIV : ST_FETCH;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_FETCH;
                end
            end
            default: state_next = ST_FETCH;
        endcase
        if ((state_next == ST_DIV) && (state_reg != ST_DIV))
        begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            flags_reg <= ev_flags;
            class_reg <= ev_class;
            score_reg <= ev_score;
            count_reg <= ev_count;
            sum_reg   <= ev_sum;
        end
        if (load_char)
        begin
            kind_reg   <= ctcg_pkg::KIND_CHAR;
            oclass_reg <= class_reg;
            oscore_reg <= score_reg;
            oconf_reg  <= '0;
            ocount_reg <= count_reg;
            last_reg   <= !flags_reg.has_sum;
        end
        else if (load_sum)
        begin
            kind_reg   <= ctcg_pkg::KIND_SUMMARY;
            oclass_reg <= '0;
            oscore_reg <= '0;
            oconf_reg  <= conf;
            ocount_reg <= count_reg;
            last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FETCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_char || load_sum)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_class = oclass_reg;
    assign out_score = oscore_reg;
    assign out_conf  = oconf_reg;
    assign out_count = ocount_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/ctc_greedy_decoder_unit.sv =====
// ctc greedy decoder top level: front end, event queue, back end with mean divider
//
// usage
//   s_axis: one class score per transfer in tdata, num_classes per time step, class 0
//   first; tlast marks the final score of a sequence (it also closes a partial step).
//   m_axis: results; tuser is the kind (0 character, 1 sequence summary), tlast marks
//   the final result caused by one input transfer.
//   cfg: register writes (index 0 num_classes, index 1 valid_keys), always ready;
//   write only while the block is idle.
// timing
//   scores are taken at one per cycle while the event queue has room.
//   a character result passes the event queue, the back end event registers and the
//   output register; a summary also waits for the bit-serial divider that forms the
//   mean score, and up to four events wait in the queue meanwhile.
// reset
//   registers return to 6625 classes and keys, sequence totals clear, outputs idle.
// stall
//   a stalled m_axis holds its result; the queue then fills and s_axis_tready drops.
`default_nettype none

module ctc_greedy_decoder_unit
#(
    parameter int MAX_CLASSES = 8192,
    parameter int MAX_CHARS   = 1024,
    localparam int CNT_W   = $clog2(MAX_CHARS + 1),
    localparam int OUT_RAW = ctcg_pkg::CLS_OUT_W + ctcg_pkg::SCORE_W + ctcg_pkg::CONF_W + CNT_W,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire                          cfg_index,
    input  wire [ctcg_pkg::CFG_W-1:0]    cfg_data,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [15:0]                   s_axis_tdata,  // score
    input  wire                          s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [OUT_W-1:0]             m_axis_tdata,  // class_index, char_score, confidence, char_count
    output logic                         m_axis_tuser,  // kind
    output logic                         m_axis_tlast
);

    localparam int Q_W = 2 + ctcg_pkg::CLS_OUT_W + ctcg_pkg::SCORE_W + CNT_W + ctcg_pkg::SUM_W;

    logic                           push;
    logic                           pop;
    logic                           q_full;
    logic                           q_empty;
    ctcg_pkg::ev_flags_t            wr_flags;
    logic [ctcg_pkg::CLS_OUT_W-1:0] wr_class;
    logic [ctcg_pkg::SCORE_W-1:0]   wr_score;
    logic [CNT_W-1:0]               wr_count;
    logic [ctcg_pkg::SUM_W-1:0]     wr_sum;
    logic [Q_W-1:0]                 q_wr;
    logic [Q_W-1:0]                 q_rd;
    ctcg_pkg::ev_flags_t            rd_flags;
    logic [ctcg_pkg::CLS_OUT_W-1:0] rd_class;
    logic [ctcg_pkg::SCORE_W-1:0]   rd_score;
    logic [CNT_W-1:0]               rd_count;
    logic [ctcg_pkg::SUM_W-1:0]     rd_sum;
    logic [ctcg_pkg::CLS_OUT_W-1:0] out_class;
    logic [ctcg_pkg::SCORE_W-1:0]   out_score;
    logic [ctcg_pkg::CONF_W-1:0]    out_conf;
    logic [CNT_W-1:0]               out_count;

    assign cfg_ready = 1'b1;

    ctcg_front #(.MAX_CLASSES(MAX_CLASSES), .MAX_CHARS(MAX_CHARS)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_score   (s_axis_tdata),
        .in_seq_end (s_axis_tlast),
        .q_full     (q_full),
        .push       (push),
        .ev_flags   (wr_flags),
        .ev_class   (wr_class),
        .ev_score   (wr_score),
        .ev_count   (wr_count),
        .ev_sum     (wr_sum)
    );

    assign q_wr = {wr_flags, wr_class, wr_score, wr_count, wr_sum};

    ctcg_fifo #(.WIDTH(Q_W), .DEPTH(4)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (q_wr),
        .pop     (pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign {rd_flags, rd_class, rd_score, rd_count, rd_sum} = q_rd;

    ctcg_back #(.MAX_CHARS(MAX_CHARS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop       (pop),
        .ev_flags  (rd_flags),
        .ev_class  (rd_class),
        .ev_score  (rd_score),
        .ev_count  (rd_count),
        .ev_sum    (rd_sum),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_class (out_class),
        .out_score (out_score),
        .out_conf  (out_conf),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({out_count, out_conf, out_score, out_class});

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ctcg_pkg::KIND_SUMMARY)) |-> m_axis_tlast)
        else $error("summary result without last");

    a_char_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ctcg_pkg::KIND_CHAR)) |->
        ((out_count != '0) && (out_conf == '0) && (out_class != '0)))
        else $error("character result with bad count, confidence or class");

    a_empty_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ctcg_pkg::KIND_SUMMARY) && (out_count == '0))
        |-> (out_conf == '0))
        else $error("nonzero confidence with no characters");

    a_push_event: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (wr_flags.has_char || wr_flags.has_sum))
        else $error("queued event carries no result");

endmodule

`default_nettype wire
